FILE: hw/rtl/byte_sequence_reorder_receiver_defines.svh
// ----------------------------------------------------------------------------
// Reorder receiver assertion macros
// Shared concurrent assertion wrappers for the reorder receiver RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_SEQUENCE_REORDER_RECEIVER_DEFINES_SVH
`define BYTE_SEQUENCE_REORDER_RECEIVER_DEFINES_SVH

// Checked only while the block is out of reset.
`define RSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// Reorder receiver package
// Slot count, status codes, state encoding and cell control types.
// ----------------------------------------------------------------------------
package rsr_pkg;

  localparam int SLOTS = 16;

  localparam logic [2:0] ST_INORDER = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_BUFFER  = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_EMIT  = 3'b100
  } rsr_state_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic [31:0] key;
    logic        clr_hit;
    logic        wr;
    logic [31:0] wr_off;
    logic [15:0] wr_len;
  } rsr_cell_ctl_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] len;
  } rsr_cell_stat_t;

  typedef struct packed {
    logic [SLOTS-1:0] hit_vec;
    logic             hit_any;
    logic             any_free;
    logic [15:0]      hit_len;
  } rsr_chain_stat_t;

endpackage

FILE: hw/rtl/rsr_in_if.sv
// ----------------------------------------------------------------------------
// Reorder receiver input channel
// Valid/ready channel carrying one packet header per word.
// ----------------------------------------------------------------------------
interface rsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] seq_num;
  logic [15:0] pkt_len;
  logic [31:0] total_len;

  modport source (output valid, output seq_num, output pkt_len, output total_len,
                  input ready);
  modport sink   (input valid, input seq_num, input pkt_len, input total_len,
                  output ready);
endinterface

FILE: hw/rtl/rsr_out_if.sv
// ----------------------------------------------------------------------------
// Reorder receiver result channel
// Valid/ready channel carrying one ack word per packet header.
// ----------------------------------------------------------------------------
interface rsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ack_num;
  logic [2:0]  status;
  logic        done_res;

  modport source (output valid, output ack_num, output status, output done_res,
                  input ready);
  modport sink   (input valid, input ack_num, input status, input done_res,
                  output ready);
endinterface

FILE: hw/rtl/byte_sequence_reorder_receiver.sv
// ----------------------------------------------------------------------------
// Byte sequence reorder receiver
// Tracks the next expected byte offset, buffers early segments and returns
// a cumulative ack for every packet header.
// ----------------------------------------------------------------------------
// One packet header is taken per word and one ack word comes back for it.
// Headers that are stale, duplicate, buffered or dropped pass from IDLE to
// EMIT and back to IDLE once their ack word is loaded. An in-order header
// passes through DRAIN first, releasing buffered segments: the drain walks the
// slot chain, retiring one matching segment per cycle by broadcasting the
// expected offset to all cells. The result sits in an output register, so a
// new header is accepted while an earlier ack word still waits to be taken.
// Slots start empty right after reset; no clearing pass is needed.
`include "byte_sequence_reorder_receiver_defines.svh"

module byte_sequence_reorder_receiver (
  input logic      clk,
  input logic      rst_n,
  rsr_in_if.sink   in_ch,
  rsr_out_if.source out_ch
);
  import rsr_pkg::*;

  rsr_state_t      state_r, state_nxt;
  logic [31:0]     exp_r, exp_nxt;
  logic [31:0]     total_r, total_nxt;
  logic            known_r, known_nxt;
  logic [2:0]      res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_ack_r;
  logic [2:0]      out_status_r;
  logic            out_done_r;
  logic            acc;
  logic            load_out;
  logic            in_order;
  logic            stale;
  rsr_cell_ctl_t   ctl;
  rsr_chain_stat_t cstat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign in_order    = (in_ch.seq_num == exp_r);
  assign stale       = (in_ch.seq_num < exp_r);
  assign load_out    = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.key     = (state_r == S_IDLE) ? in_ch.seq_num : exp_r;
    ctl.clr_hit = (state_r == S_DRAIN);
    ctl.wr      = acc && !in_order && !stale && !cstat.hit_any;
    ctl.wr_off  = in_ch.seq_num;
    ctl.wr_len  = in_ch.pkt_len;
  end

  rsr_chain u_chain (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .stat (cstat)
  );

  always_comb begin
    state_nxt      = state_r;
    exp_nxt        = exp_r;
    total_nxt      = total_r;
    known_nxt      = known_r;
    res_status_nxt = res_status_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (!known_r) begin
            total_nxt = in_ch.total_len;
            known_nxt = 1'b1;
          end
          if (in_order) begin
            exp_nxt        = exp_r + {16'd0, in_ch.pkt_len};
            res_status_nxt = ST_INORDER;
            state_nxt      = S_DRAIN;
          end else begin
            if (stale) begin
              res_status_nxt = ST_STALE;
            end else if (cstat.hit_any) begin
              res_status_nxt = ST_DUP;
            end else if (cstat.any_free) begin
              res_status_nxt = ST_BUFFER;
            end else begin
              res_status_nxt = ST_FULL;
            end
            state_nxt = S_EMIT;
          end
        end
      end
      S_DRAIN: begin
        if (cstat.hit_any) begin
          exp_nxt = exp_r + {16'd0, cstat.hit_len};
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      exp_r        <= 32'd0;
      total_r      <= 32'd0;
      known_r      <= 1'b0;
      res_status_r <= ST_INORDER;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      exp_r        <= exp_nxt;
      total_r      <= total_nxt;
      known_r      <= known_nxt;
      res_status_r <= res_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ack_r    <= exp_r;
      out_status_r <= res_status_r;
      out_done_r   <= known_r && (exp_r == total_r);
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.ack_num  = out_ack_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.done_res = out_done_r;

  `RSR_ASSERT(a_single_match, $onehot0(cstat.hit_vec), "more than one slot matched the key")
  `RSR_ASSERT(a_drain_step, (state_r == S_DRAIN) && cstat.hit_any |=> exp_r == $past(exp_r + {16'd0, cstat.hit_len}), "drain step did not advance the expected offset")
  `RSR_ASSERT(a_status_range, out_valid_r |-> out_status_r <= ST_FULL, "result word carries an undefined status")
  `RSR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r && (state_r == S_IDLE), "block not quiet after reset")

endmodule

FILE: hw/rtl/rsr_cell.sv
// ----------------------------------------------------------------------------
// Reorder receiver slot cell
// Holds one buffered segment; matches a broadcast key and claims a write
// when it is the first free cell along the chain.
// ----------------------------------------------------------------------------
module rsr_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rsr_pkg::rsr_cell_ctl_t ctl,
  input  logic                   taken_in,
  output logic                   taken_out,
  output rsr_pkg::rsr_cell_stat_t stat
);
  import rsr_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] off_r;
  logic [15:0] len_r;
  logic        hit;
  logic        grant;

  assign hit       = valid_r && (off_r == ctl.key);
  // A free cell claims the write only if no free cell sits before it.
  assign grant     = !valid_r && !taken_in;
  assign taken_out = taken_in | !valid_r;

  assign stat.hit = hit;
  assign stat.len = hit ? len_r : 16'd0;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.wr && grant) begin
      valid_nxt = 1'b1;
    end else if (ctl.clr_hit && hit) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && grant) begin
      off_r <= ctl.wr_off;
      len_r <= ctl.wr_len;
    end
  end

endmodule

FILE: hw/rtl/rsr_chain.sv
// ----------------------------------------------------------------------------
// Reorder receiver slot chain
// Row of slot cells with a free-slot priority chain and a merged match result.
// ----------------------------------------------------------------------------
module rsr_chain (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rsr_pkg::rsr_cell_ctl_t  ctl,
  output rsr_pkg::rsr_chain_stat_t stat
);
  import rsr_pkg::*;

  logic [SLOTS:0]   taken;
  rsr_cell_stat_t   cell_stat [SLOTS];
  logic [SLOTS-1:0] hit_vec;
  logic [15:0]      len_or;

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .taken_in (taken[i]),
      .taken_out(taken[i+1]),
      .stat     (cell_stat[i])
    );
    assign hit_vec[i] = cell_stat[i].hit;
  end

  // Stored offsets are unique, so at most one cell contributes a length.
  always_comb begin
    len_or = 16'd0;
    for (int i = 0; i < SLOTS; i++) begin
      len_or = len_or | cell_stat[i].len;
    end
  end

  assign stat.hit_vec  = hit_vec;
  assign stat.hit_any  = |hit_vec;
  assign stat.any_free = taken[SLOTS];
  assign stat.hit_len  = len_or;

endmodule
